>>> rtl/core/chacha_pkg.sv
// Shared types, constants and round helpers for the ChaCha20 byte cipher.
// Used by chacha20_stream_cipher; no dependencies.
package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int BLOCK_BYTES   = 64;
  localparam int BLOCK_WORDS   = BLOCK_BYTES / 4;
  localparam int DR_W          = $clog2(DOUBLE_ROUNDS);
  localparam int POS_W         = $clog2(BLOCK_BYTES);
  localparam int WADDR_W       = $clog2(BLOCK_WORDS);
  localparam int AVAIL_W       = POS_W + 1;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  typedef enum logic [2:0] {
    REG_KEY_0_63    = 3'd0,
    REG_KEY_64_127  = 3'd1,
    REG_KEY_128_191 = 3'd2,
    REG_KEY_192_255 = 3'd3,
    REG_NONCE_0_63  = 3'd4,
    REG_NONCE_64_95 = 3'd5,
    REG_INIT_CTR    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_READ,
    ST_OUT
  } state_e;

  // One quarter-round step on the fixed column a=0, b=4, c=8, d=12.
  function automatic state_t qr_step(state_t s, logic [1:0] step);
    state_t r;
    word_t  t;
    r = s;
    t = '0;
    case (step)
      2'd0: begin
        r[0]  = s[0] + s[4];
        t     = s[12] ^ r[0];
        r[12] = {t[15:0], t[31:16]};
      end
      2'd1: begin
        r[8] = s[8] + s[12];
        t    = s[4] ^ r[8];
        r[4] = {t[19:0], t[31:20]};
      end
      2'd2: begin
        r[0]  = s[0] + s[4];
        t     = s[12] ^ r[0];
        r[12] = {t[23:0], t[31:24]};
      end
      default: begin
        r[8] = s[8] + s[12];
        t    = s[4] ^ r[8];
        r[4] = {t[24:0], t[31:25]};
      end
    endcase
    return r;
  endfunction

  // Rotate each row left by col_sh, plus the row number to diagonalize or
  // minus the row number to undo it.
  function automatic state_t rot_rows(state_t s, logic [1:0] col_sh, logic diag,
                                      logic undiag);
    state_t     o;
    logic [1:0] amt;
    logic [1:0] src;
    o = s;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        amt = col_sh;
        if (diag) begin
          amt = amt + 2'(r);
        end else if (undiag) begin
          amt = amt - 2'(r);
        end
        src = 2'(j) + amt;
        o[{2'(r), 2'(j)}] = s[{2'(r), src}];
      end
    end
    return o;
  endfunction

endpackage

>>> rtl/core/chacha20_stream_cipher.sv
// ChaCha20 byte cipher: XOR each data byte with the next keystream byte.
// Depends on chacha_pkg (types, constants, quarter-round step helpers).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries data_byte_i and restart_i.
//   Output channel (out_valid_o / out_stall_i) carries data_out_o, one beat
//   per input beat, in order. A beat moves when valid is high and stall low.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready) writes key,
//   nonce and initial counter by index; unknown indexes are dropped. Write
//   only while the block is idle.
//   restart_i reloads the block counter from the initial counter and drops
//   any keystream left in the buffer before the byte is processed.
// Timing:
//   A byte served from the buffer is read from the keystream RAM (ST_READ),
//   then XORed into the output register (ST_OUT); the next byte is taken once
//   the block is back in ST_IDLE. A byte that needs a new block takes
//   4 * 8 * DOUBLE_ROUNDS quarter-round steps on the one shared add/xor/rotate
//   unit, one feed-forward add per word into the 16-word keystream RAM, then
//   the same read and output steps to the result before the next byte is taken.
//   One byte is in flight at a time; in_stall_o is high until it is done.
// Reset clears the counter, the buffer fill count and the output valid flag.
// If the receiver stalls, the result holds in the output register and the
// block holds the next finished result until it drains.
module chacha20_stream_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import chacha_pkg::*;

  // configuration
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce0_q;
  logic [31:0] nonce1_q, init_ctr_q;

  state_e               state_q, state_d;
  logic [31:0]          ctr_q, ctr_d;
  logic [AVAIL_W-1:0]   avail_q, avail_d;
  state_t               x_q, x_d;
  state_t               in_q, in_d;
  logic [1:0]           step_q, step_d;
  logic [2:0]           qr_q, qr_d;
  logic [DR_W-1:0]      dr_q, dr_d;
  logic [WADDR_W-1:0]   widx_q, widx_d;
  logic [7:0]           byte_q, byte_d;
  logic [1:0]           bsel_q, bsel_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           data_out_q, data_out_d;

  logic [31:0]          ks_mem [BLOCK_WORDS];
  logic [31:0]          rd_q;
  logic                 mem_we;
  logic [31:0]          mem_wdata;
  logic                 mem_re;
  logic [POS_W-1:0]     pos;

  logic                 in_acc;
  logic                 out_acc;
  logic [31:0]          ctr_eff;
  logic                 need_block;
  state_t               x_step;
  state_t               x_rot;
  state_t               init_st;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce0_q   <= '0;
      nonce1_q   <= '0;
      init_ctr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY_0_63:    key0_q     <= cfg_data_i;
        REG_KEY_64_127:  key1_q     <= cfg_data_i;
        REG_KEY_128_191: key2_q     <= cfg_data_i;
        REG_KEY_192_255: key3_q     <= cfg_data_i;
        REG_NONCE_0_63:  nonce0_q   <= cfg_data_i;
        REG_NONCE_64_95: nonce1_q   <= cfg_data_i[31:0];
        REG_INIT_CTR:    init_ctr_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign ctr_eff    = restart_i ? init_ctr_q : ctr_q;
  assign need_block = restart_i || (avail_q == '0);

  always_comb begin
    init_st[0]  = SIGMA0;
    init_st[1]  = SIGMA1;
    init_st[2]  = SIGMA2;
    init_st[3]  = SIGMA3;
    init_st[4]  = key0_q[31:0];
    init_st[5]  = key0_q[63:32];
    init_st[6]  = key1_q[31:0];
    init_st[7]  = key1_q[63:32];
    init_st[8]  = key2_q[31:0];
    init_st[9]  = key2_q[63:32];
    init_st[10] = key3_q[31:0];
    init_st[11] = key3_q[63:32];
    init_st[12] = ctr_eff;
    init_st[13] = nonce0_q[31:0];
    init_st[14] = nonce0_q[63:32];
    init_st[15] = nonce1_q;
  end

  // Shared round unit; after the last step of a quarter round, move the next
  // column into place, and switch between column and diagonal layout.
  always_comb begin
    x_step = qr_step(x_q, step_q);
    x_rot  = rot_rows(x_step, 2'd1, qr_q == 3'd3, qr_q == 3'd7);
  end

  assign pos       = POS_W'(AVAIL_W'(BLOCK_BYTES) - avail_q);
  assign mem_wdata = x_q[0] + in_q[0];

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    avail_d     = avail_q;
    x_d         = x_q;
    in_d        = in_q;
    step_d      = step_q;
    qr_d        = qr_q;
    dr_d        = dr_q;
    widx_d      = widx_q;
    byte_d      = byte_q;
    bsel_d      = bsel_q;
    out_valid_d = out_valid_q;
    data_out_d  = data_out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          byte_d = data_byte_i;
          if (need_block) begin
            x_d     = init_st;
            in_d    = init_st;
            ctr_d   = ctr_eff + 32'd1;
            avail_d = '0;
            step_d  = '0;
            qr_d    = '0;
            dr_d    = '0;
            state_d = ST_ROUND;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_ROUND: begin
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          x_d  = x_rot;
          qr_d = qr_q + 3'd1;
          if (qr_q == 3'd7) begin
            if (dr_q == DR_W'(DOUBLE_ROUNDS - 1)) begin
              widx_d  = '0;
              state_d = ST_FEED;
            end else begin
              dr_d = dr_q + DR_W'(1);
            end
          end
        end else begin
          x_d = x_step;
        end
      end
      ST_FEED: begin
        // feed-forward one word per cycle, shifting both states down
        mem_we = 1'b1;
        for (int i = 0; i < 16; i++) begin
          x_d[4'(i)]  = x_q[4'(i + 1)];
          in_d[4'(i)] = in_q[4'(i + 1)];
        end
        widx_d = widx_q + WADDR_W'(1);
        if (widx_q == WADDR_W'(BLOCK_WORDS - 1)) begin
          avail_d = AVAIL_W'(BLOCK_BYTES);
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        bsel_d  = pos[1:0];
        avail_d = avail_q - AVAIL_W'(1);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          data_out_d  = byte_q ^ rd_q[{bsel_q, 3'b000} +: 8];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      avail_q     <= '0;
      step_q      <= '0;
      qr_q        <= '0;
      dr_q        <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      avail_q     <= avail_d;
      step_q      <= step_d;
      qr_q        <= qr_d;
      dr_q        <= dr_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    in_q       <= in_d;
    byte_q     <= byte_d;
    bsel_q     <= bsel_d;
    data_out_q <= data_out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ks_mem[widx_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= ks_mem[pos[POS_W-1:2]];
    end
  end

endmodule
